// ----- rtl/lrb_pkg.sv -----
`default_nettype none

package lrb_pkg;

   localparam int NumSections = 6;
   localparam int ByteW       = 8;
   localparam int SecW        = 3;
   localparam int LedW        = 6;
   localparam int RingW       = 40;
   localparam int ShiftBits   = NumSections * ByteW;
   localparam int CntW        = 6;

   localparam logic [3:0] OP_WRITE     = 4'd0;
   localparam logic [3:0] OP_OR        = 4'd1;
   localparam logic [3:0] OP_AND       = 4'd2;
   localparam logic [3:0] OP_LOAD      = 4'd3;
   localparam logic [3:0] OP_SET_LED   = 4'd4;
   localparam logic [3:0] OP_ROTATE    = 4'd5;
   localparam logic [3:0] OP_READ_SEC  = 4'd6;
   localparam logic [3:0] OP_READ_LED  = 4'd7;
   localparam logic [3:0] OP_CLEAR     = 4'd8;
   localparam logic [3:0] OP_REFRESH   = 4'd9;

   localparam logic [SecW-1:0] SEC_LIMIT = SecW'(NumSections);
   localparam logic [LedW-1:0] LED_LIMIT = LedW'(RingW);
   localparam logic [CntW-1:0] LAST_BIT  = CntW'(ShiftBits - 1);
   localparam logic [5:0]      STEP_WRAP = 6'(RingW);

   typedef logic [ByteW-1:0] byte_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_ANSWER
   } state_type;

   typedef struct packed {
      logic apply;
      logic shift;
      logic answer;
   } cmd_type;

   // Wheel LEDs are grouped by eight: white, green, blue, red, yellow.
   function automatic logic [SecW-1:0] led_section(input logic [LedW-1:0] n);
      logic [SecW-1:0] s;
      case (n[5:3])
         3'd0:    s = 3'd3;
         3'd1:    s = 3'd2;
         3'd2:    s = 3'd1;
         3'd3:    s = 3'd5;
         3'd4:    s = 3'd4;
         default: s = 3'd0;
      endcase
      return s;
   endfunction

   function automatic byte_type led_mask(input logic [LedW-1:0] n);
      return byte_type'(8'h80 >> n[2:0]);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/lrb_ctrl.sv -----
`default_nettype none

module lrb_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [3:0]      op,
   input  wire logic            do_refresh,
   input  wire logic            last_bit,
   output logic                 busy,
   output lrb_pkg::cmd_type     cmd
);
   import lrb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (op) inside
                  OP_WRITE, OP_OR, OP_AND, OP_SET_LED, OP_ROTATE:
                     state_in = do_refresh ? ST_SHIFT : ST_IDLE;
                  OP_LOAD, OP_CLEAR, OP_REFRESH:
                     state_in = ST_SHIFT;
                  OP_READ_SEC, OP_READ_LED:
                     state_in = ST_ANSWER;
                  default:
                     state_in = ST_IDLE;
               endcase
            end
         end
         ST_SHIFT: begin
            if (last_bit) state_in = ST_IDLE;
         end
         ST_ANSWER: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy       = (state_ff != ST_IDLE);
      cmd.apply  = (state_ff == ST_IDLE) && start;
      cmd.shift  = (state_ff == ST_SHIFT);
      cmd.answer = (state_ff == ST_ANSWER);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/lrb_datapath.sv -----
`default_nettype none

module lrb_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lrb_pkg::cmd_type       cmd,
   input  wire logic [3:0]             op,
   input  wire logic [lrb_pkg::SecW-1:0] section,
   input  wire logic [7:0]             data_byte,
   input  wire logic [lrb_pkg::LedW-1:0] led_number,
   input  wire logic                   direction,
   input  wire logic [5:0]             steps,
   input  wire logic [lrb_pkg::RingW-1:0] wheel_bits,
   output logic                        last_bit,
   output logic                        out_kind,
   output logic                        out_serial_bit,
   output logic                        out_latch_enable,
   output logic [7:0]                  out_read_data,
   output logic                        out_last
);
   import lrb_pkg::*;

   byte_type                store_ff [NumSections];
   byte_type                store_in [NumSections];
   logic                    enable_ff;
   logic [ShiftBits-1:0]    shift_ff;
   logic [CntW-1:0]         cnt_ff;
   byte_type                answer_ff;
   byte_type                answer_in;

   logic                    led_op;
   logic                    led_ok;
   logic                    sec_ok;
   logic [SecW-1:0]         addr;
   logic                    addr_ok;
   byte_type                sel_byte;
   byte_type                mask;
   logic [RingW-1:0]        ring;
   logic [RingW-1:0]        ring_rot;
   logic [2*RingW-1:0]      ring_dbl;
   logic [2*RingW-1:0]      ring_sh;
   logic [5:0]              step_mod;

   // One read address serves both the section ops and the wheel LED ops.
   always_comb begin
      led_op   = (op == OP_SET_LED) || (op == OP_READ_LED);
      led_ok   = (led_number < LED_LIMIT);
      sec_ok   = (section < SEC_LIMIT);
      mask     = led_mask(led_number);
      addr     = led_op ? led_section(led_number) : section;
      addr_ok  = led_op ? led_ok : sec_ok;
      sel_byte = addr_ok ? store_ff[addr] : '0;
   end

   always_comb begin
      ring     = {store_ff[5], store_ff[4], store_ff[3], store_ff[2], store_ff[1]};
      step_mod = (steps >= STEP_WRAP) ? steps - STEP_WRAP : steps;
      ring_dbl = {ring, ring};
      if (direction) begin
         ring_sh  = ring_dbl << step_mod;
         ring_rot = ring_sh[2*RingW-1:RingW];
      end else begin
         ring_sh  = ring_dbl >> step_mod;
         ring_rot = ring_sh[RingW-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < NumSections; i++) begin
         store_in[i] = store_ff[i];
      end
      answer_in = '0;
      case (op)
         OP_WRITE: begin
            if (sec_ok) store_in[addr] = data_byte;
         end
         OP_OR: begin
            if (sec_ok) store_in[addr] = sel_byte | data_byte;
         end
         OP_AND: begin
            if (sec_ok) store_in[addr] = sel_byte & data_byte;
         end
         OP_LOAD: begin
            for (int i = 1; i < NumSections; i++) begin
               store_in[i] = wheel_bits[(i-1)*ByteW +: ByteW];
            end
         end
         OP_SET_LED: begin
            if (led_ok) begin
               store_in[addr] = (data_byte != '0) ? (sel_byte | mask) : (sel_byte & ~mask);
            end
         end
         OP_ROTATE: begin
            for (int i = 1; i < NumSections; i++) begin
               store_in[i] = ring_rot[(i-1)*ByteW +: ByteW];
            end
         end
         OP_READ_SEC: begin
            answer_in = sel_byte;
         end
         OP_READ_LED: begin
            answer_in = byte_type'((sel_byte & mask) != '0);
         end
         OP_CLEAR: begin
            for (int i = 0; i < NumSections; i++) begin
               store_in[i] = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumSections; i++) begin
            store_ff[i] <= '0;
         end
         enable_ff <= 1'b0;
         cnt_ff    <= '0;
      end else if (cmd.apply) begin
         for (int i = 0; i < NumSections; i++) begin
            store_ff[i] <= store_in[i];
         end
         cnt_ff <= '0;
      end else if (cmd.shift) begin
         cnt_ff <= cnt_ff + CntW'(1);
         if (last_bit) enable_ff <= 1'b1;
      end
   end

   // The shift line holds the updated buffer, last section and MSB first.
   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         shift_ff  <= {store_in[5], store_in[4], store_in[3],
                       store_in[2], store_in[1], store_in[0]};
         answer_ff <= answer_in;
      end else if (cmd.shift) begin
         shift_ff <= {shift_ff[ShiftBits-2:0], 1'b0};
      end
   end

   always_comb begin
      last_bit         = (cnt_ff == LAST_BIT);
      out_kind         = cmd.answer;
      out_serial_bit   = cmd.shift & shift_ff[ShiftBits-1];
      out_latch_enable = cmd.shift ? last_bit : enable_ff;
      out_read_data    = cmd.answer ? answer_ff : '0;
      out_last         = cmd.answer | (cmd.shift & last_bit);
   end

endmodule

`default_nettype wire

// ----- rtl/led_ring_buffer_shift_driver_unit.sv -----
`default_nettype none
// LED ring buffer shift driver.
// An item is taken at a clock edge where start is high and busy is low; its op
// updates the six-section LED buffer at that same edge. busy stays high while
// results are being sent and no new item is taken.
// Results leave on the rsp_ ports, one per cycle, each marked by rsp_valid for
// exactly one cycle; the receiver cannot hold them off.
// A refresh sends 48 serial bits, last section first and MSB first, after the
// item is taken, one bit per cycle from the shift line; latch enable is low
// on the first 47 bits and high on the last.
// A read sends one answer in the cycle after the item is taken.
// An item that causes no result leaves busy low, so the next item may follow
// in the next cycle. Synchronous reset clears the buffer, the enable level
// and the controller; no item is in flight afterwards.
module led_ring_buffer_shift_driver_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [3:0]                 req_op,
   input  wire logic [lrb_pkg::SecW-1:0]   req_section,
   input  wire logic [7:0]                 req_data_byte,
   input  wire logic [lrb_pkg::LedW-1:0]   req_led_number,
   input  wire logic                       req_direction,
   input  wire logic [5:0]                 req_steps,
   input  wire logic                       req_do_refresh,
   input  wire logic [lrb_pkg::RingW-1:0]  req_wheel_bits,
   output logic                            rsp_valid,
   output logic                            rsp_kind,
   output logic                            rsp_serial_bit,
   output logic                            rsp_latch_enable,
   output logic [7:0]                      rsp_read_data,
   output logic                            rsp_last
);
   import lrb_pkg::*;

   cmd_type cmd;
   logic    last_bit;

   lrb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .op         (req_op),
      .do_refresh (req_do_refresh),
      .last_bit   (last_bit),
      .busy       (busy),
      .cmd        (cmd)
   );

   lrb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .op               (req_op),
      .section          (req_section),
      .data_byte        (req_data_byte),
      .led_number       (req_led_number),
      .direction        (req_direction),
      .steps            (req_steps),
      .wheel_bits       (req_wheel_bits),
      .last_bit         (last_bit),
      .out_kind         (rsp_kind),
      .out_serial_bit   (rsp_serial_bit),
      .out_latch_enable (rsp_latch_enable),
      .out_read_data    (rsp_read_data),
      .out_last         (rsp_last)
   );

   assign rsp_valid = cmd.shift | cmd.answer;

endmodule

`default_nettype wire

// ----- test/led_ring_buffer_shift_driver_unit_test.sv -----
`default_nettype none

module led_ring_buffer_shift_driver_unit_test;
   import lrb_pkg::*;

   localparam logic [3:0] OP_SPARE_FIRST = 4'd10;
   localparam logic [3:0] OP_SPARE_LAST  = 4'd15;
   localparam int RANDOM_ITEMS = 330;
   localparam int TAIL_CYCLES  = 60;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 60;

   typedef struct packed {
      logic     kind;
      logic     serial_bit;
      logic     latch_enable;
      byte_type read_data;
      logic     last;
   } led_output_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [3:0]            req_op;
   logic [SecW-1:0]       req_section;
   logic [7:0]            req_data_byte;
   logic [LedW-1:0]       req_led_number;
   logic                  req_direction;
   logic [5:0]            req_steps;
   logic                  req_do_refresh;
   logic [RingW-1:0]      req_wheel_bits;
   logic                  rsp_valid;
   logic                  rsp_kind;
   logic                  rsp_serial_bit;
   logic                  rsp_latch_enable;
   logic [7:0]            rsp_read_data;
   logic                  rsp_last;

   // Shadow copy of the LED buffer and the enable level.
   byte_type              shadow_sections [NumSections];
   logic                  shadow_enable;
   led_output_type        led_outputs_due [$];
   int                    mismatch_count;
   int                    cycle_count;
   int                    calm_run;

   led_ring_buffer_shift_driver_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_section      (req_section),
      .req_data_byte    (req_data_byte),
      .req_led_number   (req_led_number),
      .req_direction    (req_direction),
      .req_steps        (req_steps),
      .req_do_refresh   (req_do_refresh),
      .req_wheel_bits   (req_wheel_bits),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_serial_bit   (rsp_serial_bit),
      .rsp_latch_enable (rsp_latch_enable),
      .rsp_read_data    (rsp_read_data),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Wheel LEDs come in groups of eight: white, green, blue, red, yellow.
   // Returns zero for a number beyond the ring.
   function automatic logic [SecW-1:0] wheel_led_home(input logic [LedW-1:0] n,
                                                      output byte_type m);
      logic [SecW-1:0] s;
      m = 8'h80 >> n[2:0];
      case (n[5:3])
         3'd0:    s = 3'd3;
         3'd1:    s = 3'd2;
         3'd2:    s = 3'd1;
         3'd3:    s = 3'd5;
         3'd4:    s = 3'd4;
         default: s = 3'd0;
      endcase
      return s;
   endfunction

   task automatic model_led_cmd(input logic [3:0] op, input logic [SecW-1:0] sec,
                                input byte_type data, input logic [LedW-1:0] led,
                                input logic dir, input logic [5:0] steps,
                                input logic refresh_req, input logic [RingW-1:0] wheel);
      logic               refresh;
      logic [SecW-1:0]    home;
      byte_type           mask;
      logic [RingW-1:0]   ring;
      logic [2*RingW-1:0] twin;
      int                 amount;
      led_output_type     item;
      refresh = refresh_req;
      item = '0;
      case (op)
         OP_WRITE:
            if (sec < SEC_LIMIT) shadow_sections[sec] = data;
         OP_OR:
            if (sec < SEC_LIMIT) shadow_sections[sec] = shadow_sections[sec] | data;
         OP_AND:
            if (sec < SEC_LIMIT) shadow_sections[sec] = shadow_sections[sec] & data;
         OP_LOAD: begin
            {shadow_sections[5], shadow_sections[4], shadow_sections[3],
             shadow_sections[2], shadow_sections[1]} = wheel;
            refresh = 1'b1;
         end
         OP_SET_LED: begin
            home = wheel_led_home(led, mask);
            if (home != 0) begin
               if (data != 0) shadow_sections[home] = shadow_sections[home] | mask;
               else           shadow_sections[home] = shadow_sections[home] & ~mask;
            end
         end
         OP_ROTATE: begin
            amount = steps % RingW;
            if (amount != 0) begin
               ring = {shadow_sections[5], shadow_sections[4], shadow_sections[3],
                       shadow_sections[2], shadow_sections[1]};
               twin = {ring, ring};
               if (dir) begin
                  twin = twin << amount;
                  ring = twin[2*RingW-1 -: RingW];
               end else begin
                  twin = twin >> amount;
                  ring = twin[RingW-1:0];
               end
               {shadow_sections[5], shadow_sections[4], shadow_sections[3],
                shadow_sections[2], shadow_sections[1]} = ring;
            end
         end
         OP_READ_SEC, OP_READ_LED: begin
            item.kind         = 1'b1;
            item.latch_enable = shadow_enable;
            item.last         = 1'b1;
            if (op == OP_READ_SEC) begin
               item.read_data = (sec < SEC_LIMIT) ? shadow_sections[sec] : 8'd0;
            end else begin
               home = wheel_led_home(led, mask);
               item.read_data = (home != 0 && (shadow_sections[home] & mask) != 0)
                                ? 8'd1 : 8'd0;
            end
            led_outputs_due.push_back(item);
            refresh = 1'b0;
         end
         OP_CLEAR: begin
            foreach (shadow_sections[i]) shadow_sections[i] = '0;
            refresh = 1'b1;
         end
         OP_REFRESH:
            refresh = 1'b1;
         default:
            refresh = 1'b0;
      endcase
      if (refresh) begin
         // The chain takes the last section first, each byte MSB first.
         for (int s = NumSections - 1; s >= 0; s--) begin
            for (int b = ByteW - 1; b >= 0; b--) begin
               item              = '0;
               item.serial_bit   = shadow_sections[s][b];
               item.latch_enable = (s == 0 && b == 0);
               item.last         = (s == 0 && b == 0);
               led_outputs_due.push_back(item);
            end
         end
         shadow_enable = 1'b1;
      end
   endtask

   always @(posedge clock) begin : result_check
      led_output_type want;
      if (!reset && rsp_valid) begin
         if (led_outputs_due.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $error("result arrived with nothing outstanding");
            mismatch_count++;
         end else begin
            want = led_outputs_due.pop_front();
            if (rsp_kind !== want.kind) begin
               if (mismatch_count < MAX_REPORTS)
                  $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               mismatch_count++;
            end
            if (rsp_serial_bit !== want.serial_bit) begin
               if (mismatch_count < MAX_REPORTS)
                  $error("serial_bit: expected %0d, got %0d", want.serial_bit,
                         rsp_serial_bit);
               mismatch_count++;
            end
            if (rsp_latch_enable !== want.latch_enable) begin
               if (mismatch_count < MAX_REPORTS)
                  $error("latch_enable: expected %0d, got %0d", want.latch_enable,
                         rsp_latch_enable);
               mismatch_count++;
            end
            if (rsp_read_data !== want.read_data) begin
               if (mismatch_count < MAX_REPORTS)
                  $error("read_data: expected 0x%02h, got 0x%02h", want.read_data,
                         rsp_read_data);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               if (mismatch_count < MAX_REPORTS)
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   // Mostly random gaps, with the odd run of back-to-back items.
   function automatic int draw_gap();
      int gap;
      if (calm_run > 0) begin
         calm_run--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 11);
         if ($urandom_range(0, 15) == 0) calm_run = $urandom_range(5, 20);
      end
      return gap;
   endfunction

   task automatic send_cmd(input logic [3:0] op, input logic [SecW-1:0] sec,
                           input byte_type data, input logic [LedW-1:0] led,
                           input logic dir, input logic [5:0] steps,
                           input logic refresh_req, input logic [RingW-1:0] wheel);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start          <= 1'b1;
      req_op         <= op;
      req_section    <= sec;
      req_data_byte  <= data;
      req_led_number <= led;
      req_direction  <= dir;
      req_steps      <= steps;
      req_do_refresh <= refresh_req;
      req_wheel_bits <= wheel;
      @(posedge clock);
      while (busy) @(posedge clock);
      model_led_cmd(op, sec, data, led, dir, steps, refresh_req, wheel);
   endtask

   task automatic go_quiet();
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic test_section_ops();
      // A read before any refresh must still show the outputs disabled.
      send_cmd(OP_READ_SEC, 3'd0, 8'h00, 6'd0, 1'b0, 6'd0, 1'b0, '0);
      send_cmd(OP_WRITE,    3'd0, 8'hFF, 6'd0, 1'b0, 6'd0, 1'b1, '0);
      send_cmd(OP_WRITE,    3'd5, 8'hA5, 6'd0, 1'b1, 6'd63, 1'b0, '1);
      send_cmd(OP_OR,       3'd5, 8'h5A, 6'd0, 1'b0, 6'd0, 1'b0, '0);
      send_cmd(OP_AND,      3'd5, 8'h00, 6'd0, 1'b0, 6'd0, 1'b1, '0);
      send_cmd(OP_WRITE,    3'd7, 8'h33, 6'd0, 1'b0, 6'd0, 1'b1, '0);
      send_cmd(OP_READ_SEC, 3'd6, 8'h00, 6'd0, 1'b0, 6'd0, 1'b0, '0);
      send_cmd(OP_READ_SEC, 3'd0, 8'h00, 6'd0, 1'b0, 6'd0, 1'b0, '0);
   endtask

   task automatic test_wheel_leds();
      send_cmd(OP_LOAD,     3'd0, 8'h00, 6'd0,  1'b0, 6'd0, 1'b0, 40'hFF_FFFF_FFFF);
      send_cmd(OP_SET_LED,  3'd0, 8'h00, 6'd0,  1'b0, 6'd0, 1'b0, '0);
      send_cmd(OP_SET_LED,  3'd0, 8'h00, 6'd39, 1'b0, 6'd0, 1'b1, '0);
      send_cmd(OP_READ_LED, 3'd0, 8'h00, 6'd0,  1'b0, 6'd0, 1'b0, '0);
      send_cmd(OP_READ_LED, 3'd0, 8'h00, 6'd38, 1'b0, 6'd0, 1'b0, '0);
      send_cmd(OP_SET_LED,  3'd0, 8'hFF, 6'd63, 1'b0, 6'd0, 1'b1, '0);
      send_cmd(OP_READ_LED, 3'd0, 8'h00, 6'd63, 1'b0, 6'd0, 1'b0, '0);
      send_cmd(OP_LOAD,     3'd0, 8'h00, 6'd0,  1'b0, 6'd0, 1'b0, 40'h00_0000_0000);
      send_cmd(OP_SET_LED,  3'd0, 8'h01, 6'd16, 1'b0, 6'd0, 1'b1, '0);
   endtask

   task automatic test_rotation();
      send_cmd(OP_LOAD,   3'd0, 8'h00, 6'd0, 1'b0, 6'd0,  1'b0, 40'h80_0000_0001);
      send_cmd(OP_ROTATE, 3'd0, 8'h00, 6'd0, 1'b1, 6'd1,  1'b1, '0);
      send_cmd(OP_ROTATE, 3'd0, 8'h00, 6'd0, 1'b0, 6'd39, 1'b0, '0);
      send_cmd(OP_ROTATE, 3'd0, 8'h00, 6'd0, 1'b1, 6'd0,  1'b1, '0);
      send_cmd(OP_ROTATE, 3'd0, 8'h00, 6'd0, 1'b0, 6'd40, 1'b1, '0);
      send_cmd(OP_ROTATE, 3'd0, 8'h00, 6'd0, 1'b1, 6'd63, 1'b1, '0);
   endtask

   task automatic test_clear_and_spare_ops();
      send_cmd(OP_CLEAR,       3'd0, 8'h00, 6'd0, 1'b0, 6'd0, 1'b0, '0);
      send_cmd(OP_REFRESH,     3'd0, 8'h00, 6'd0, 1'b0, 6'd0, 1'b0, '0);
      send_cmd(OP_SPARE_LAST,  3'd7, 8'hFF, 6'd63, 1'b1, 6'd63, 1'b1, '1);
      send_cmd(OP_SPARE_FIRST, 3'd0, 8'h00, 6'd0, 1'b0, 6'd0, 1'b1, '0);
   endtask

   task automatic test_random_traffic();
      int               counted;
      logic [3:0]       op;
      logic [SecW-1:0]  sec;
      byte_type         data;
      logic [LedW-1:0]  led;
      logic [RingW-1:0] wheel;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         // Spare ops are noise and do not count towards the total.
         if ($urandom_range(0, 19) == 0) begin
            op = 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         end else begin
            op = 4'($urandom_range(OP_WRITE, OP_REFRESH));
            counted++;
         end
         sec = ($urandom_range(0, 9) == 0) ? SecW'($urandom_range(NumSections, 7))
                                           : SecW'($urandom_range(0, NumSections - 1));
         led = ($urandom_range(0, 7) == 0) ? LedW'($urandom_range(RingW, 63))
                                           : LedW'($urandom_range(0, RingW - 1));
         data  = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
         wheel = {8'($urandom), 32'($urandom)};
         send_cmd(op, sec, data, led, 1'($urandom), 6'($urandom_range(0, 63)),
                  1'($urandom), wheel);
      end
   endtask

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_op         <= OP_WRITE;
      req_section    <= '0;
      req_data_byte  <= '0;
      req_led_number <= '0;
      req_direction  <= 1'b0;
      req_steps      <= '0;
      req_do_refresh <= 1'b0;
      req_wheel_bits <= '0;
      foreach (shadow_sections[i]) shadow_sections[i] = '0;
      shadow_enable  = 1'b0;
      mismatch_count = 0;
      cycle_count    = 0;
      calm_run       = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_section_ops();
      test_wheel_leds();
      test_rotation();
      test_clear_and_spare_ops();
      test_random_traffic();

      go_quiet();
      while (led_outputs_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
